// ===== rtl/assert_macros.svh =====
// Assertion macros for the gate sequencer RTL.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SBGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SBGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbgs_pkg.sv =====
// Shared types, codes and helpers of the single-button gate sequencer.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package sbgs_pkg;

  // Field widths
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PULSE_W = 24;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned QUO_W   = 10;

  // Q10 unity
  localparam logic [POS_W-1:0] Q_ONE = 11'd1024;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POSREQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd2;

  // Direction / operation codes
  localparam logic [OP_W-1:0] OP_IDLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_OPENING = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSING = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TRAVEL    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MIN_DELTA = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PULSE     = 2'd2;

  // Configuration reset values
  localparam logic [DIST_W-1:0]  TRAVEL_RST    = 16'd1000;
  localparam logic [POS_W-1:0]   MIN_DELTA_RST = 11'd51;
  localparam logic [PULSE_W-1:0] PULSE_RST     = 24'd500000;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // latch accepted input transaction
    logic div_start;  // start distance-to-position divide
    logic apply;      // commit state update and write result register
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_done;   // divide result valid
    logic out_free;   // result register can take a new transaction
  } dp_sts_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [OP_W-1:0] opposite_of(input logic [OP_W-1:0] dir);
    opposite_of = (dir == OP_CLOSING) ? OP_OPENING : OP_CLOSING;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbgs_div.sv =====
// Iterative restoring divider: position = 1024 - round(distance*1024/travel), floored at 0.
// Depends on sbgs_pkg. One quotient bit per cycle after a load cycle.
`default_nettype none

module sbgs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [sbgs_pkg::DIST_W-1:0] dist_in,
  input  wire logic [sbgs_pkg::DIST_W-1:0] travel,
  output logic                             done,
  output logic [sbgs_pkg::POS_W-1:0]       pos
);

  localparam int unsigned NUM_W = sbgs_pkg::DIST_W + sbgs_pkg::QUO_W + 1;
  localparam int unsigned DSH_W = sbgs_pkg::DIST_W + sbgs_pkg::QUO_W - 1;
  localparam int unsigned CNT_W = $clog2(sbgs_pkg::QUO_W);

  logic [sbgs_pkg::DIST_W-1:0] tdiv;
  logic [NUM_W-1:0]            num;
  logic [NUM_W-1:0]            lim;
  logic [NUM_W-1:0]            dsh_ext;
  logic                        fits;

  logic [NUM_W-1:0]              rem_r;
  logic [DSH_W-1:0]              dsh_r;
  logic [sbgs_pkg::QUO_W-1:0]    quo_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          sat_r;
  logic                          busy_r;
  logic                          done_r;

  // Zero travel acts as one; numerator carries the rounding half
  assign tdiv    = (travel == '0) ? {{(sbgs_pkg::DIST_W-1){1'b0}}, 1'b1} : travel;
  assign num     = {1'b0, dist_in, {sbgs_pkg::QUO_W{1'b0}}}
                 + {{(NUM_W-sbgs_pkg::DIST_W+1){1'b0}}, tdiv[sbgs_pkg::DIST_W-1:1]};
  assign lim     = {1'b0, tdiv, {sbgs_pkg::QUO_W{1'b0}}};
  assign dsh_ext = {2'b00, dsh_r};
  assign fits    = (rem_r >= dsh_ext);

  // Control: busy while stepping, done held until next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(sbgs_pkg::QUO_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Datapath: one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {tdiv, {(sbgs_pkg::QUO_W-1){1'b0}}};
      quo_r <= '0;
      sat_r <= (num >= lim);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_ext;
      end
      quo_r <= {quo_r[sbgs_pkg::QUO_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign pos  = sat_r ? '0 : (sbgs_pkg::Q_ONE - {1'b0, quo_r});

endmodule

`default_nettype wire

// ===== rtl/sbgs_ctrl.sv =====
// Controller state machine of the gate sequencer.
// Depends on sbgs_pkg; drives sbgs_dp through ctrl_cmd_t, reads dp_sts_t.
`default_nettype none

module sbgs_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [sbgs_pkg::FUNC_W-1:0] in_func,
  input  wire logic                        in_distance_valid,
  input  wire sbgs_pkg::dp_sts_t           sts,
  output logic                             in_ready,
  output sbgs_pkg::ctrl_cmd_t              cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_func == sbgs_pkg::FUNC_SAMPLE && in_distance_valid) begin
            state_nxt = S_START;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbgs_dp.sv =====
// Datapath of the gate sequencer: config registers, gate state, divider, result register.
// Depends on sbgs_pkg and sbgs_div; controlled by sbgs_ctrl.
`default_nettype none

module sbgs_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sbgs_pkg::ctrl_cmd_t          cmd,
  output sbgs_pkg::dp_sts_t                 sts,
  // input transaction
  input  wire logic [sbgs_pkg::FUNC_W-1:0]  in_func,
  input  wire logic                         in_distance_valid,
  input  wire logic [sbgs_pkg::DIST_W-1:0]  in_distance,
  input  wire logic [sbgs_pkg::POS_W-1:0]   in_target_position,
  input  wire logic [sbgs_pkg::TIME_W-1:0]  in_now_us,
  // configuration write
  input  wire logic                         cfg_we,
  input  wire logic [sbgs_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [sbgs_pkg::PULSE_W-1:0] cfg_data,
  // result
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [sbgs_pkg::POS_W-1:0]        out_position,
  output logic                              out_position_changed,
  output logic [sbgs_pkg::OP_W-1:0]         out_operation,
  output logic                              out_button_active
);

  // Configuration
  logic [sbgs_pkg::DIST_W-1:0]  travel_r;
  logic [sbgs_pkg::POS_W-1:0]   min_delta_r;
  logic [sbgs_pkg::PULSE_W-1:0] pulse_time_r;

  // Latched input transaction
  logic [sbgs_pkg::FUNC_W-1:0] func_r;
  logic                        dvalid_r;
  logic [sbgs_pkg::DIST_W-1:0] dist_r;
  logic [sbgs_pkg::POS_W-1:0]  target_r;
  logic [sbgs_pkg::TIME_W-1:0] now_r;

  // Gate state
  logic [sbgs_pkg::POS_W-1:0]  gate_pos_r,  gate_pos_nxt;
  logic [sbgs_pkg::OP_W-1:0]   cur_op_r,    cur_op_nxt;
  logic [sbgs_pkg::OP_W-1:0]   req_dir_r,   req_dir_nxt;
  logic [sbgs_pkg::OP_W-1:0]   exp_dir_r,   exp_dir_nxt;
  logic                        press_pend_r, press_pend_nxt;
  logic                        pulse_run_r, pulse_run_nxt;
  logic [sbgs_pkg::TIME_W-1:0] deadline_r,  deadline_nxt;
  logic                        rev_pend_r,  rev_pend_nxt;
  logic                        changed_nxt;

  // Result register
  logic                        out_valid_r;
  logic [sbgs_pkg::POS_W-1:0]  out_pos_r;
  logic                        out_chg_r;
  logic [sbgs_pkg::OP_W-1:0]   out_op_r;
  logic                        out_btn_r;

  // Helpers
  logic [sbgs_pkg::POS_W-1:0]  div_pos;
  logic                        div_done;
  logic [sbgs_pkg::POS_W-1:0]  target_sat;
  logic [sbgs_pkg::TIME_W-1:0] past;
  logic                        expired;

  sbgs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dist_in (dist_r),
    .travel  (travel_r),
    .done    (div_done),
    .pos     (div_pos)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r     <= sbgs_pkg::TRAVEL_RST;
      min_delta_r  <= sbgs_pkg::MIN_DELTA_RST;
      pulse_time_r <= sbgs_pkg::PULSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbgs_pkg::CFG_TRAVEL:    travel_r     <= cfg_data[sbgs_pkg::DIST_W-1:0];
        sbgs_pkg::CFG_MIN_DELTA: min_delta_r  <= cfg_data[sbgs_pkg::POS_W-1:0];
        sbgs_pkg::CFG_PULSE:     pulse_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      dvalid_r <= in_distance_valid;
      dist_r   <= in_distance;
      target_r <= in_target_position;
      now_r    <= in_now_us;
    end
  end

  assign target_sat = (target_r > sbgs_pkg::Q_ONE) ? sbgs_pkg::Q_ONE : target_r;
  // Deadline passed: wrapped difference in 1 .. 2^31-1
  assign past       = now_r - deadline_r;
  assign expired    = (past != '0) && !past[sbgs_pkg::TIME_W-1];

  // State update for one transaction
  always_comb begin
    gate_pos_nxt   = gate_pos_r;
    cur_op_nxt     = cur_op_r;
    req_dir_nxt    = req_dir_r;
    exp_dir_nxt    = exp_dir_r;
    press_pend_nxt = press_pend_r;
    pulse_run_nxt  = pulse_run_r;
    deadline_nxt   = deadline_r;
    rev_pend_nxt   = rev_pend_r;
    changed_nxt    = 1'b0;
    case (func_r)
      sbgs_pkg::FUNC_SAMPLE: begin
        if (dvalid_r && (sbgs_pkg::abs_diff(div_pos, gate_pos_r) > min_delta_r)) begin
          gate_pos_nxt = div_pos;
          changed_nxt  = 1'b1;
        end
        // press poll
        if (press_pend_r) begin
          if (!pulse_run_r) begin
            pulse_run_nxt = 1'b1;
            deadline_nxt  = now_r + {8'd0, pulse_time_r};
          end else if (expired) begin
            press_pend_nxt = 1'b0;
            pulse_run_nxt  = 1'b0;
            // direction tracking
            if (req_dir_r == sbgs_pkg::OP_IDLE) begin
              exp_dir_nxt = sbgs_pkg::opposite_of(exp_dir_r);
            end else if (rev_pend_r) begin
              rev_pend_nxt   = 1'b0;
              press_pend_nxt = 1'b1;
              exp_dir_nxt    = req_dir_r;
            end else if (req_dir_r != exp_dir_r) begin
              rev_pend_nxt   = 1'b1;
              press_pend_nxt = 1'b1;
            end else begin
              rev_pend_nxt = 1'b0;
              exp_dir_nxt  = sbgs_pkg::opposite_of(req_dir_r);
            end
          end
        end
      end
      sbgs_pkg::FUNC_POSREQ: begin
        if (sbgs_pkg::abs_diff(target_sat, gate_pos_r) >= min_delta_r) begin
          cur_op_nxt     = (target_sat > gate_pos_r) ? sbgs_pkg::OP_CLOSING
                                                     : sbgs_pkg::OP_OPENING;
          req_dir_nxt    = cur_op_nxt;
          press_pend_nxt = 1'b1;
          gate_pos_nxt   = target_sat;
          changed_nxt    = 1'b1;
        end
      end
      sbgs_pkg::FUNC_STOP: begin
        req_dir_nxt    = sbgs_pkg::OP_IDLE;
        press_pend_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Gate state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_pos_r   <= '0;
      cur_op_r     <= sbgs_pkg::OP_IDLE;
      req_dir_r    <= sbgs_pkg::OP_IDLE;
      exp_dir_r    <= sbgs_pkg::OP_IDLE;
      press_pend_r <= 1'b0;
      pulse_run_r  <= 1'b0;
      deadline_r   <= '0;
      rev_pend_r   <= 1'b0;
    end else if (cmd.apply) begin
      gate_pos_r   <= gate_pos_nxt;
      cur_op_r     <= cur_op_nxt;
      req_dir_r    <= req_dir_nxt;
      exp_dir_r    <= exp_dir_nxt;
      press_pend_r <= press_pend_nxt;
      pulse_run_r  <= pulse_run_nxt;
      deadline_r   <= deadline_nxt;
      rev_pend_r   <= rev_pend_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_pos_r <= gate_pos_nxt;
      out_chg_r <= changed_nxt;
      out_op_r  <= cur_op_nxt;
      out_btn_r <= pulse_run_nxt;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_position         = out_pos_r;
  assign out_position_changed = out_chg_r;
  assign out_operation        = out_op_r;
  assign out_button_active    = out_btn_r;

endmodule

`default_nettype wire

// ===== rtl/single_button_gate_sequencer_unit.sv =====
// Top level of the single-button gate sequencer: controller plus datapath.
// Depends on sbgs_pkg, sbgs_ctrl, sbgs_dp (with sbgs_div) and assert_macros.svh.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_ready   func, distance_valid, distance, target_position, now_us
//   out_     out  out_valid/out_ready position, position_changed, operation, button_active
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// A sample transaction with a valid distance passes from acceptance to the next acceptance
// through load, divider start, ten restoring steps, done check and writeback; other
// transactions go through load and writeback only. One transaction is in flight at a time.
// The result register holds a finished result while the next transaction is taken;
// writeback waits only if that register is still full. Synchronous active-low reset.
`default_nettype none
`include "assert_macros.svh"

module single_button_gate_sequencer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sbgs_pkg::FUNC_W-1:0]  in_func,
  input  wire logic                         in_distance_valid,
  input  wire logic [sbgs_pkg::DIST_W-1:0]  in_distance,
  input  wire logic [sbgs_pkg::POS_W-1:0]   in_target_position,
  input  wire logic [sbgs_pkg::TIME_W-1:0]  in_now_us,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sbgs_pkg::POS_W-1:0]        out_position,
  output logic                              out_position_changed,
  output logic [sbgs_pkg::OP_W-1:0]         out_operation,
  output logic                              out_button_active,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sbgs_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [sbgs_pkg::PULSE_W-1:0] cfg_data
);

  sbgs_pkg::ctrl_cmd_t ctrl_cmd;
  sbgs_pkg::dp_sts_t   dp_sts;

  assign cfg_ready = 1'b1;

  sbgs_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_func           (in_func),
    .in_distance_valid (in_distance_valid),
    .sts               (dp_sts),
    .in_ready          (in_ready),
    .cmd               (ctrl_cmd)
  );

  sbgs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (ctrl_cmd),
    .sts                  (dp_sts),
    .in_func              (in_func),
    .in_distance_valid    (in_distance_valid),
    .in_distance          (in_distance),
    .in_target_position   (in_target_position),
    .in_now_us            (in_now_us),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_position         (out_position),
    .out_position_changed (out_position_changed),
    .out_operation        (out_operation),
    .out_button_active    (out_button_active)
  );

  // Assertions
  `SBGS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `SBGS_ASSERT_NOW(a_pos_range, out_valid, out_position <= sbgs_pkg::Q_ONE, "position above one")
  `SBGS_ASSERT_NEXT(a_out_drain, out_valid && out_ready && !ctrl_cmd.apply, !out_valid, "result repeated")

endmodule

`default_nettype wire

// ===== tb/single_button_gate_sequencer_unit_tb.sv =====
// Self-checking testbench for the single-button gate sequencer.
// Depends on sbgs_pkg and the single_button_gate_sequencer_unit RTL; uses a scoreboard class
// that predicts every result and random valid/ready pacing on both channels.
module single_button_gate_sequencer_unit_tb;
  import sbgs_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_UNUSED  = 2'd3;

  // Cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              distance_valid;
    logic [DIST_W-1:0] distance;
    logic [POS_W-1:0]  target_position;
    logic [TIME_W-1:0] now_us;
  } gate_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             position_changed;
    logic [OP_W-1:0]  operation;
    logic             button_active;
  } gate_result_t;

  // Predicts the gate state per accepted transaction and checks results in order
  class gate_scoreboard;
    logic [DIST_W-1:0]  travel;
    logic [POS_W-1:0]   delta;
    logic [PULSE_W-1:0] pulse_len;
    logic [POS_W-1:0]   gate_pos;
    logic [OP_W-1:0]    op_now;
    logic [OP_W-1:0]    dir_req;
    logic [OP_W-1:0]    dir_exp;
    logic               press_wait;
    logic               pulse_on;
    logic               reverse_wait;
    logic [TIME_W-1:0]  deadline;
    gate_result_t       expected_q[$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      travel       = TRAVEL_RST;
      delta        = MIN_DELTA_RST;
      pulse_len    = PULSE_RST;
      gate_pos     = '0;
      op_now       = OP_IDLE;
      dir_req      = OP_IDLE;
      dir_exp      = OP_IDLE;
      press_wait   = 1'b0;
      pulse_on     = 1'b0;
      reverse_wait = 1'b0;
      deadline     = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [CIDX_W-1:0] idx, logic [PULSE_W-1:0] data);
      case (idx)
        CFG_TRAVEL:    travel = data[DIST_W-1:0];
        CFG_MIN_DELTA: delta = data[POS_W-1:0];
        CFG_PULSE:     pulse_len = data;
        default: ;
      endcase
    endfunction

    function logic [POS_W-1:0] pos_gap(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function logic [OP_W-1:0] reverse_of(logic [OP_W-1:0] dir);
      return (dir == OP_CLOSING) ? OP_OPENING : OP_CLOSING;
    endfunction

    // Q10 position: 1024 - round(distance * 1024 / travel), floored at 0
    function logic [POS_W-1:0] position_of(logic [DIST_W-1:0] reading);
      logic [63:0] span;
      logic [63:0] quot;
      span = (travel == '0) ? 64'd1 : 64'(travel);
      quot = (64'(reading) * 64'(Q_ONE) + span / 2) / span;
      return (quot >= 64'(Q_ONE)) ? '0 : POS_W'(64'(Q_ONE) - quot);
    endfunction

    // After each finished press: decide whether another press is needed
    function void follow_direction();
      if (dir_req == OP_IDLE) begin
        dir_exp = reverse_of(dir_exp);
      end else if (reverse_wait) begin
        reverse_wait = 1'b0;
        press_wait   = 1'b1;
        dir_exp      = dir_req;
      end else if (dir_req != dir_exp) begin
        reverse_wait = 1'b1;
        press_wait   = 1'b1;
      end else begin
        reverse_wait = 1'b0;
        dir_exp      = reverse_of(dir_req);
      end
    endfunction

    // Start a pulse, or end it once the timestamp is past the deadline (mod 2^32)
    function void press_poll(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] late;
      if (!pulse_on) begin
        pulse_on = 1'b1;
        deadline = now + TIME_W'(pulse_len);
      end else begin
        late = now - deadline;
        if (late != '0 && !late[TIME_W-1]) begin
          press_wait = 1'b0;
          pulse_on   = 1'b0;
          follow_direction();
        end
      end
    endfunction

    function void note_input(gate_item_t it);
      logic [POS_W-1:0] fresh;
      logic [POS_W-1:0] goal;
      logic             changed;
      changed = 1'b0;
      case (it.func)
        FUNC_SAMPLE: begin
          if (it.distance_valid) begin
            fresh = position_of(it.distance);
            if (pos_gap(fresh, gate_pos) > delta) begin
              gate_pos = fresh;
              changed  = 1'b1;
            end
          end
          if (press_wait) press_poll(it.now_us);
        end
        FUNC_POSREQ: begin
          goal = (it.target_position > Q_ONE) ? Q_ONE : it.target_position;
          if (pos_gap(goal, gate_pos) >= delta) begin
            op_now     = (goal > gate_pos) ? OP_CLOSING : OP_OPENING;
            dir_req    = op_now;
            press_wait = 1'b1;
            gate_pos   = goal;
            changed    = 1'b1;
          end
        end
        FUNC_STOP: begin
          dir_req    = OP_IDLE;
          press_wait = 1'b1;
        end
        default: ;
      endcase
      expected_q.push_back('{gate_pos, changed, op_now, pulse_on});
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_REPORTS) $display("MISMATCH result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_result(gate_result_t got);
      gate_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, position %0d", got.position));
        return;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, expected %0d", got.position, want.position));
      if (got.position_changed !== want.position_changed)
        report_mismatch($sformatf("position_changed %0b, expected %0b",
                                  got.position_changed, want.position_changed));
      if (got.operation !== want.operation)
        report_mismatch($sformatf("operation %0d, expected %0d", got.operation, want.operation));
      if (got.button_active !== want.button_active)
        report_mismatch($sformatf("button_active %0b, expected %0b",
                                  got.button_active, want.button_active));
    endtask
  endclass

  // Clock, reset and block ports
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_SAMPLE;
  logic              in_distance_valid = 1'b0;
  logic [DIST_W-1:0] in_distance = '0;
  logic [POS_W-1:0]  in_target_position = '0;
  logic [TIME_W-1:0] in_now_us = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_position;
  logic              out_position_changed;
  logic [OP_W-1:0]   out_operation;
  logic              out_button_active;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index = CFG_TRAVEL;
  logic [PULSE_W-1:0] cfg_data = '0;

  gate_scoreboard    sb;
  logic              full_rate = 1'b0;
  logic [TIME_W-1:0] now_base = '0;
  int unsigned       idle_cycles = 0;

  always #2 clk = ~clk;

  single_button_gate_sequencer_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_distance_valid   (in_distance_valid),
    .in_distance         (in_distance),
    .in_target_position  (in_target_position),
    .in_now_us           (in_now_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_position        (out_position),
    .out_position_changed(out_position_changed),
    .out_operation       (out_operation),
    .out_button_active   (out_button_active),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Send one input transaction, then idle for a random gap (none at full rate)
  task automatic drive_item(input logic [FUNC_W-1:0] func, input logic dv,
                            input logic [DIST_W-1:0] dist_val, input logic [POS_W-1:0] target,
                            input logic [TIME_W-1:0] now);
    gate_item_t  it;
    int unsigned gap;
    it = '{func, dv, dist_val, target, now};
    in_func            <= func;
    in_distance_valid  <= dv;
    in_distance        <= dist_val;
    in_target_position <= target;
    in_now_us          <= now;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    gap = full_rate ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [PULSE_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [PULSE_W-1:0] travel_data,
                           input logic [PULSE_W-1:0] delta_data,
                           input logic [PULSE_W-1:0] pulse_data);
    write_register(CFG_TRAVEL, travel_data);
    write_register(CFG_MIN_DELTA, delta_data);
    write_register(CFG_PULSE, pulse_data);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic: mostly samples on an advancing clock so presses run to completion
  task automatic run_random(input int unsigned count);
    int unsigned       done_items;
    int unsigned       pick;
    int unsigned       lim;
    int unsigned       step;
    logic [FUNC_W-1:0] func;
    logic              dv;
    logic [DIST_W-1:0] dist_val;
    logic [POS_W-1:0]  target;
    done_items = 0;
    while (done_items < count) begin
      if (done_items % 100 == 0) full_rate = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) func = FUNC_SAMPLE;
      else if (pick < 85) func = FUNC_POSREQ;
      else if (pick < 97) func = FUNC_STOP;
      else func = FUNC_UNUSED;
      dv = ($urandom_range(0, 7) != 0);
      // distances mostly around the travel span, some anywhere
      lim = int'(sb.travel) + int'(sb.travel) / 8;
      if (lim > 65535) lim = 65535;
      dist_val = ($urandom_range(0, 9) < 7) ? DIST_W'($urandom_range(0, lim))
                                            : DIST_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 10) target = ($urandom_range(0, 1) != 0) ? Q_ONE : '0;
      else if (pick < 80) target = POS_W'($urandom_range(0, 1024));
      else target = POS_W'($urandom_range(0, 2047));
      // timestamp: mostly forward steps of up to about half the pulse length, some jumps anywhere
      step = int'(sb.pulse_len) / 2 + 16;
      pick = $urandom_range(0, 99);
      if (pick < 4) now_base = $urandom();
      else if (pick >= 10) now_base = now_base + TIME_W'($urandom_range(0, step));
      drive_item(func, dv, dist_val, target, now_base);
      if (func != FUNC_UNUSED) done_items++;
    end
  endtask

  // Result side: random backpressure, check every accepted result
  initial begin : result_sink
    int unsigned  stall;
    gate_result_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_position, out_position_changed, out_operation, out_button_active};
        sb.check_result(got);
        stall = full_rate ? 0 : $urandom_range(0, 16);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: no transaction on any channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks at reset configuration; the second pulse deadline wraps past 2^32
    t0 = 32'hFFF8_0000;
    t1 = t0 + 32'd500001;
    t2 = t1 + 32'd1100000 + 32'h7FFF_FFFF;
    drive_item(FUNC_SAMPLE, 1'b1, 16'd0, 11'd0, t0);            // fully closed reading
    drive_item(FUNC_SAMPLE, 1'b0, 16'hFFFF, 11'h7FF, t0);       // invalid reading ignored
    drive_item(FUNC_SAMPLE, 1'b1, 16'hFFFF, 11'd0, t0);         // beyond travel clamps to 0
    drive_item(FUNC_SAMPLE, 1'b1, 16'd500, 11'd0, t0);          // midpoint
    drive_item(FUNC_SAMPLE, 1'b1, 16'd480, 11'd0, t0);          // move within delta
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'd520, t0);          // request below delta
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'h7FF, t0);          // target saturates, closing
    drive_item(FUNC_UNUSED, 1'b1, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF);
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t0);            // pulse starts
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t0 + 32'd500000); // at deadline, still on
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t1);            // ends, reversal press queued
    drive_item(FUNC_SAMPLE, 1'b1, 16'hFFFF, 11'd0, t1);         // update and new pulse together
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t1 + 32'd600000); // repeat press queued
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t1 + 32'd600000);
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t1 + 32'd1100000 + 32'h8000_0000); // not past
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t2);            // farthest past, direction met
    drive_item(FUNC_STOP, 1'b0, 16'd0, 11'd0, t2);
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t2);
    drive_item(FUNC_SAMPLE, 1'b0, 16'd0, 11'd0, t2 + 32'd500001); // stop press done
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'd51, t2);           // change equal to delta acts
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'd0, t2);            // opening
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'd1024, t2);         // closing to the end
    drive_item(FUNC_POSREQ, 1'b0, 16'd0, 11'd0, t2);
    drive_item(FUNC_SAMPLE, 1'b1, 16'd949, 11'd0, t2);          // one above delta: update
    drive_item(FUNC_SAMPLE, 1'b1, 16'd899, 11'd0, t2);          // equal to delta: no update
    now_base = t2;
    run_random(300);
    finish_phase();

    // Widest travel, zero delta, zero-length pulse (upper data bits ignored)
    configure(24'hAB_FFFF, 24'h00_0000, 24'h00_0000);
    run_random(280);
    finish_phase();

    // Shortest travel, full-scale delta, longest pulse
    configure(24'h12_0001, 24'h00_F400, 24'hFF_FFFF);
    run_random(280);
    finish_phase();

    // Zero travel, delta beyond range, unused register index
    configure(24'h00_0000, 24'h00_07FF, 24'h00_0001);
    write_register(CFG_UNUSED, 24'hFF_FFFF);
    run_random(120);
    finish_phase();

    configure(PULSE_W'($urandom_range(2, 65535)), PULSE_W'($urandom_range(0, 150)),
              PULSE_W'($urandom_range(0, 24'h0F_FFFF)));
    run_random(300);
    finish_phase();

    configure(PULSE_W'(TRAVEL_RST), PULSE_W'(MIN_DELTA_RST), PULSE_RST);
    run_random(300);
    finish_phase();

    // Let any stray result show up before the verdict
    repeat (32) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbgs_pkg.sv
rtl/sbgs_div.sv
rtl/sbgs_ctrl.sv
rtl/sbgs_dp.sv
rtl/single_button_gate_sequencer_unit.sv
tb/single_button_gate_sequencer_unit_tb.sv
